### rtl/rgb_to_hsv_converter_defines.svh
// Assertion macros for the RGB to HSV converter.
// Included by files that check their own logic; needs clk and rst in scope.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RTHSV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rthsv check failed");

// next-cycle implication
`define RTHSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rthsv check failed");

`endif

### rtl/rthsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
package rthsv_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int CHAN_W = 8;
  localparam int HSV_W = 16;
  localparam int NUM_W = 11;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] rem_s;
    logic [NUM_W-1:0]  div_h;
    logic [NUM_W-1:0]  rem_h;
    logic              sat_zero;
    logic              sat_full;
    logic              hue_zero;
  } div_state_t;

endpackage

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, top level: front end, division pipeline, output register.
// Depends on rthsv_pkg, rthsv_prep, rthsv_div_step and the defines header.
`timescale 1ns / 1ps
// Takes one 8-bit RGB pixel per clock while pixel_ready is high and returns hue and
// saturation as Q0.FRAC_BITS fractions (low 16 bits) and brightness as the largest
// channel. The pipeline is two front-end stages, one stage per quotient bit of the
// two restoring dividers, and the output register. Throughput is one pixel per
// clock while the output takes results; stalls fill bubbles so the input keeps
// taking pixels while any stage is empty, even with a result waiting at the output.
module rgb_to_hsv_converter #(
  parameter int FRAC_BITS = rthsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [rthsv_pkg::CHAN_W-1:0] red,
  input  logic [rthsv_pkg::CHAN_W-1:0] green,
  input  logic [rthsv_pkg::CHAN_W-1:0] blue,
  output logic                        hsv_valid,
  input  logic                        hsv_ready,
  output logic [rthsv_pkg::HSV_W-1:0] hue,
  output logic [rthsv_pkg::HSV_W-1:0] saturation,
  output logic [rthsv_pkg::CHAN_W-1:0] brightness
);
  import rthsv_pkg::*;
  `include "rgb_to_hsv_converter_defines.svh"

  localparam int ExtW = (FRAC_BITS > HSV_W) ? FRAC_BITS : HSV_W;

  div_state_t           st  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] qs  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] qh  [0:FRAC_BITS];
  logic                 sv  [0:FRAC_BITS];
  logic                 sr  [0:FRAC_BITS];
  logic                 ov;
  logic                 ordy;
  logic [FRAC_BITS-1:0] sat_c, hue_c;
  logic [ExtW-1:0]      sat_ext, hue_ext;

  rthsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_ready  (pixel_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (sv[0]),
    .out_ready (sr[0]),
    .out_st    (st[0])
  );

  assign qs[0] = '0;
  assign qh[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    rthsv_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[i]),
      .in_ready  (sr[i]),
      .in_st     (st[i]),
      .in_qs     (qs[i]),
      .in_qh     (qh[i]),
      .out_valid (sv[i+1]),
      .out_ready (sr[i+1]),
      .out_st    (st[i+1]),
      .out_qs    (qs[i+1]),
      .out_qh    (qh[i+1])
    );
  end

  assign ordy              = !ov || hsv_ready;
  assign sr[FRAC_BITS]     = ordy;
  assign hsv_valid         = ov;

  always_comb begin
    if (st[FRAC_BITS].sat_zero) sat_c = '0;
    else if (st[FRAC_BITS].sat_full) sat_c = '1;
    else sat_c = qs[FRAC_BITS];
    hue_c   = st[FRAC_BITS].hue_zero ? '0 : qh[FRAC_BITS];
    sat_ext = ExtW'(sat_c);
    hue_ext = ExtW'(hue_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ordy) begin
      ov <= sv[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ordy && sv[FRAC_BITS]) begin
      hue        <= hue_ext[HSV_W-1:0];
      saturation <= sat_ext[HSV_W-1:0];
      brightness <= st[FRAC_BITS].mx;
    end
  end

  // empty output register means the whole pipeline can take a pixel
  `RTHSV_ASSERT_NOW(a_ready_when_empty, !hsv_valid, pixel_ready)
  // black pixel gives zero hue and saturation
  `RTHSV_ASSERT_NOW(a_black_zero, hsv_valid && brightness == '0,
                    saturation == '0 && hue == '0)
  // a result taken with nothing behind it leaves the output empty
  `RTHSV_ASSERT_NEXT(a_drain, hsv_valid && hsv_ready && !sv[FRAC_BITS], !hsv_valid)

endmodule

### rtl/rthsv_prep.sv
// Front end: max/min and sector (stage 1), difference, hue numerator and divisor (stage 2).
// Depends on rthsv_pkg.
`timescale 1ns / 1ps
module rthsv_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rthsv_pkg::CHAN_W-1:0] red,
  input  logic [rthsv_pkg::CHAN_W-1:0] green,
  input  logic [rthsv_pkg::CHAN_W-1:0] blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rthsv_pkg::div_state_t      out_st
);
  import rthsv_pkg::*;

  logic                v1, v2;
  logic                rdy1, rdy2;
  logic [CHAN_W-1:0]   r1, g1, b1, mx1, mn1;
  sector_t             sec1;
  logic [CHAN_W-1:0]   mx_c, mn_c;
  sector_t             sec_c;
  logic [CHAN_W-1:0]   d_c;
  logic [NUM_W-1:0]    d6_c, base_c;
  logic signed [11:0]  diff_c, num_c;
  div_state_t          st_c, st2;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;
  assign out_st    = st2;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_c = SEC_RED;
      mx_c  = red;
    end else if (green >= blue) begin
      sec_c = SEC_GREEN;
      mx_c  = green;
    end else begin
      sec_c = SEC_BLUE;
      mx_c  = blue;
    end
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
  end

  always_comb begin
    d_c  = mx1 - mn1;
    d6_c = NUM_W'({d_c, 2'b00}) + NUM_W'({d_c, 1'b0});
    unique case (sec1)
      SEC_RED: begin
        base_c = '0;
        diff_c = $signed({4'b0, g1}) - $signed({4'b0, b1});
      end
      SEC_GREEN: begin
        base_c = NUM_W'({d_c, 1'b0});
        diff_c = $signed({4'b0, b1}) - $signed({4'b0, r1});
      end
      SEC_BLUE: begin
        base_c = NUM_W'({d_c, 2'b00});
        diff_c = $signed({4'b0, r1}) - $signed({4'b0, g1});
      end
      default: begin
        base_c = '0;
        diff_c = '0;
      end
    endcase
    num_c = $signed({1'b0, base_c}) + diff_c;
    if (num_c[11]) num_c = num_c + $signed({1'b0, d6_c});
    st_c.mx       = mx1;
    st_c.rem_s    = d_c;
    st_c.div_h    = d6_c;
    st_c.rem_h    = num_c[NUM_W-1:0];
    st_c.sat_zero = (mx1 == '0);
    st_c.sat_full = (mn1 == '0) && (mx1 != '0);
    st_c.hue_zero = (d_c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1   <= red;
      g1   <= green;
      b1   <= blue;
      mx1  <= mx_c;
      mn1  <= mn_c;
      sec1 <= sec_c;
    end
    if (rdy2 && v1) st2 <= st_c;
  end

endmodule

### rtl/rthsv_div_step.sv
// One restoring-division step for both saturation and hue quotients, registered.
// Depends on rthsv_pkg.
`timescale 1ns / 1ps
module rthsv_div_step #(
  parameter int FRAC_BITS = rthsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rthsv_pkg::div_state_t in_st,
  input  logic [FRAC_BITS-1:0]  in_qs,
  input  logic [FRAC_BITS-1:0]  in_qh,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rthsv_pkg::div_state_t out_st,
  output logic [FRAC_BITS-1:0]  out_qs,
  output logic [FRAC_BITS-1:0]  out_qh
);
  import rthsv_pkg::*;

  logic               v;
  logic               rdy;
  logic [CHAN_W:0]    rs2;
  logic [NUM_W:0]     rh2;
  logic               bit_s, bit_h;
  div_state_t         st_c;

  assign rdy       = !v || out_ready;
  assign in_ready  = rdy;
  assign out_valid = v;

  always_comb begin
    rs2   = {in_st.rem_s, 1'b0};
    rh2   = {in_st.rem_h, 1'b0};
    bit_s = rs2 >= {1'b0, in_st.mx};
    bit_h = rh2 >= {1'b0, in_st.div_h};
    st_c  = in_st;
    st_c.rem_s = bit_s ? CHAN_W'(rs2 - {1'b0, in_st.mx}) : rs2[CHAN_W-1:0];
    st_c.rem_h = bit_h ? NUM_W'(rh2 - {1'b0, in_st.div_h}) : rh2[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      out_st <= st_c;
      out_qs <= {in_qs[FRAC_BITS-2:0], bit_s};
      out_qh <= {in_qh[FRAC_BITS-2:0], bit_h};
    end
  end

endmodule
